[rtl/dwl_pkg.sv]
`default_nettype none
package dwl_pkg;

	localparam int NODE_DEPTH_DEF  = 65536;
	localparam int LETTER_BITS_DEF = 16;
	localparam int FIELD_W         = 16;
	localparam int ADDR_LIMIT      = 65535;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} dwl_state_t;

	typedef struct packed {
		logic               operation;
		logic [FIELD_W-1:0] node_address;
		logic [FIELD_W-1:0] node_letter;
		logic               node_is_word;
		logic               node_is_last;
		logic [FIELD_W-1:0] node_offset;
		logic [FIELD_W-1:0] letter;
		logic               word_end;
	} dwl_in_t;

	typedef struct packed {
		logic found;
		logic table_fault;
	} dwl_out_t;

endpackage
`default_nettype wire

[rtl/dawg_word_lookup.sv]
`default_nettype none
// word lookup against a directed acyclic word graph held in a node store
//
// a transaction is taken when start is high and busy is low. item.operation
// selects a node write (store entry at item.node_address) or the lookup of
// one character of a word (item.letter, item.word_end on the last one).
// a node write gives no result.
// a lookup scans the current sibling list one node per cycle out of the
// dual-port node memory (registered read), with busy high until the scan
// stops; a character of a word that already failed does no scan and leaves
// busy low.
// on the last character of a word, done pulses for one cycle with result,
// in the cycle after the scan ends; the receiver cannot stall it, the result
// must be taken in that cycle. a new transaction may start in that cycle.
// reset returns the lookup to the root list with no fault pending; the node
// memory is not cleared and only written entries may be looked up.
module dawg_word_lookup import dwl_pkg::*; #(
	parameter int NODE_DEPTH  = NODE_DEPTH_DEF,
	parameter int LETTER_BITS = LETTER_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire dwl_in_t item,
	output logic         busy,
	output logic         done,
	output dwl_out_t     result
);

	localparam int AW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
	localparam int EW = LETTER_BITS + 2 + FIELD_W;

	logic          we;
	logic [AW-1:0] waddr;
	logic [EW-1:0] wdata;
	logic [AW-1:0] raddr;
	logic [EW-1:0] rdata;

	dwl_scan_ctrl #(
		.NODE_DEPTH  (NODE_DEPTH),
		.LETTER_BITS (LETTER_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr  (raddr),
		.rdata  (rdata)
	);

	dwl_node_store #(
		.NODE_DEPTH  (NODE_DEPTH),
		.LETTER_BITS (LETTER_BITS)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

endmodule
`default_nettype wire

[rtl/dwl_node_store.sv]
`default_nettype none
module dwl_node_store import dwl_pkg::*; #(
	parameter int NODE_DEPTH  = NODE_DEPTH_DEF,
	parameter int LETTER_BITS = LETTER_BITS_DEF,
	localparam int AW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1,
	localparam int EW = LETTER_BITS + 2 + FIELD_W
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [EW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [EW-1:0] rdata
);

	logic [EW-1:0] mem [NODE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[rtl/dwl_scan_ctrl.sv]
`default_nettype none
module dwl_scan_ctrl import dwl_pkg::*; #(
	parameter int NODE_DEPTH  = NODE_DEPTH_DEF,
	parameter int LETTER_BITS = LETTER_BITS_DEF,
	localparam int AW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1,
	localparam int EW = LETTER_BITS + 2 + FIELD_W
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire dwl_in_t       item,
	output logic               busy,
	output logic               done,
	output dwl_out_t           result,
	output logic               we,
	output logic [AW-1:0]      waddr,
	output logic [EW-1:0]      wdata,
	output logic [AW-1:0]      raddr,
	input  wire logic [EW-1:0] rdata
);

	localparam int SW = AW + 1;
	localparam int CW = ((AW > FIELD_W) ? AW : FIELD_W) + 1;
	localparam int WORD_POS = LETTER_BITS;
	localparam int LAST_POS = LETTER_BITS + 1;
	localparam int OFF_LO   = LETTER_BITS + 2;

	dwl_state_t state_q, state_d;

	logic [AW-1:0]          list_start_q, list_start_d;
	logic                   alive_q, alive_d;
	logic                   fault_q, fault_d;
	logic [AW-1:0]          scan_q, scan_d;
	logic [LETTER_BITS-1:0] want_q, want_d;
	logic                   final_q, final_d;
	logic                   done_q, done_d;
	dwl_out_t               result_q, result_d;

	logic [LETTER_BITS-1:0] node_letter;
	logic                   node_word;
	logic                   node_last;
	logic [FIELD_W-1:0]     node_off;
	logic                   match;
	logic [SW-1:0]          next_addr;
	logic                   past_end;
	logic [CW-1:0]          child;
	logic                   child_bad;
	logic                   scan_stop;
	logic                   in_range;
	logic                   fin_char;
	logic                   finish;
	logic                   hit_word;

	assign node_letter = rdata[LETTER_BITS-1:0];
	assign node_word   = rdata[WORD_POS];
	assign node_last   = rdata[LAST_POS];
	assign node_off    = rdata[OFF_LO +: FIELD_W];
	assign match       = node_letter == want_q;
	assign next_addr   = SW'(scan_q) + SW'(1);
	assign past_end    = next_addr == SW'(NODE_DEPTH);
	assign child       = CW'(scan_q) + CW'(node_off);
	assign child_bad   = (child >= CW'(NODE_DEPTH)) || (child > CW'(ADDR_LIMIT));
	assign scan_stop   = match || node_last || past_end;
	assign in_range    = 32'(item.node_address) < 32'(NODE_DEPTH);
	assign fin_char    = (state_q == ST_SCAN) ? final_q : item.word_end;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && item.operation == OP_LOOKUP && alive_q) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_stop) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and datapath updates
	always_comb begin
		list_start_d = list_start_q;
		alive_d      = alive_q;
		fault_d      = fault_q;
		scan_d       = scan_q;
		want_d       = want_q;
		final_d      = final_q;
		done_d       = 1'b0;
		result_d     = result_q;
		finish       = 1'b0;
		hit_word     = 1'b0;
		busy         = state_q != ST_IDLE;
		we           = 1'b0;
		waddr        = AW'(item.node_address);
		wdata        = {item.node_offset, item.node_is_last, item.node_is_word,
		                LETTER_BITS'(item.node_letter)};
		raddr        = list_start_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (item.operation == OP_WRITE) begin
						we = in_range;
					end else begin
						want_d  = LETTER_BITS'(item.letter);
						final_d = item.word_end;
						scan_d  = list_start_q;
						// a dead word only waits for its last character
						finish  = !alive_q;
					end
				end
			end
			ST_SCAN: begin
				raddr = next_addr[AW-1:0];
				scan_d = next_addr[AW-1:0];
				if (match) begin
					finish = 1'b1;
					if (final_q) begin
						hit_word = node_word;
					end else if (node_off == '0) begin
						alive_d = 1'b0;
					end else if (child_bad) begin
						fault_d = 1'b1;
						alive_d = 1'b0;
					end else begin
						list_start_d = child[AW-1:0];
					end
				end else if (node_last) begin
					finish  = 1'b1;
					alive_d = 1'b0;
				end else if (past_end) begin
					finish  = 1'b1;
					fault_d = 1'b1;
					alive_d = 1'b0;
				end
			end
			default: ;
		endcase
		if (finish && fin_char) begin
			done_d               = 1'b1;
			result_d.found       = alive_d && hit_word;
			result_d.table_fault = fault_d;
			list_start_d         = '0;
			alive_d              = 1'b1;
			fault_d              = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			list_start_q <= '0;
			alive_q      <= 1'b1;
			fault_q      <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			state_q      <= state_d;
			list_start_q <= list_start_d;
			alive_q      <= alive_d;
			fault_q      <= fault_d;
			done_q       <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		scan_q   <= scan_d;
		want_q   <= want_d;
		final_q  <= final_d;
		result_q <= result_d;
	end

	assign done   = done_q;
	assign result = result_q;

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_SCAN || (start && !busy)))
		else $error("result strobe without a finished scan or transaction");

	a_word_restart: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (list_start_q == '0 && alive_q && !fault_q))
		else $error("word state not back at root after result");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == ST_IDLE))
		else $error("store written during a scan");

	a_found_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(result_q.found && result_q.table_fault))
		else $error("found reported together with table fault");

endmodule
`default_nettype wire

[tb/tb_dawg_word_lookup.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_dawg_word_lookup;
	import dwl_pkg::*;

	localparam int NODES = NODE_DEPTH_DEF;
	localparam int LB    = LETTER_BITS_DEF;

	typedef struct packed {
		logic [FIELD_W-1:0] letter;
		logic               is_word;
		logic               is_last;
		logic [FIELD_W-1:0] offset;
	} node_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	dwl_in_t  item = '0;
	logic     busy;
	logic     done;
	dwl_out_t result;

	dawg_word_lookup dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.done(done),
		.result(result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow of the node store and of the word walk
	node_t              node_mem [0:NODES-1];
	int unsigned        cur_list = 0;
	bit                 word_ok = 1'b1;
	bit                 fault_flag = 1'b0;
	dwl_out_t           verdict_q[$];
	int                 mismatches = 0;
	int                 sent_items = 0;
	int                 gap_pct = 10;
	logic [FIELD_W-1:0] letter_pool [4];

	// one character of the current word, or one node write
	function automatic void follow_letter(input dwl_in_t it);
		int unsigned a;
		int unsigned child;
		bit          hit;
		bit          stop;
		logic [LB-1:0] want;
		node_t       n;
		dwl_out_t    v;
		if (it.operation == OP_WRITE) begin
			if (it.node_address < NODES)
				node_mem[it.node_address] = '{it.node_letter, it.node_is_word,
					it.node_is_last, it.node_offset};
			return;
		end
		want = it.letter[LB-1:0];
		hit = 1'b0;
		if (word_ok) begin
			a = cur_list;
			stop = 1'b0;
			while (!stop) begin
				if (a >= NODES) begin
					fault_flag = 1'b1;
					word_ok = 1'b0;
					stop = 1'b1;
				end else begin
					n = node_mem[a];
					if (n.letter[LB-1:0] == want) begin
						stop = 1'b1;
						if (it.word_end) begin
							hit = n.is_word;
						end else if (n.offset == 0) begin
							word_ok = 1'b0;
						end else begin
							child = a + n.offset;
							if (child >= NODES || child > ADDR_LIMIT) begin
								fault_flag = 1'b1;
								word_ok = 1'b0;
							end else begin
								cur_list = child;
							end
						end
					end else if (n.is_last) begin
						word_ok = 1'b0;
						stop = 1'b1;
					end else begin
						a++;
					end
				end
			end
		end
		if (it.word_end) begin
			v.found = word_ok && hit;
			v.table_fault = fault_flag;
			verdict_q.push_back(v);
			cur_list = 0;
			word_ok = 1'b1;
			fault_flag = 1'b0;
		end
	endfunction

	function automatic dwl_in_t make_write(input int unsigned addr, input logic [15:0] ltr,
			input bit w, input bit l, input logic [15:0] off);
		dwl_in_t it;
		it = dwl_in_t'({$urandom, $urandom, $urandom});
		it.operation = OP_WRITE;
		it.node_address = addr[15:0];
		it.node_letter = ltr;
		it.node_is_word = w;
		it.node_is_last = l;
		it.node_offset = off;
		return it;
	endfunction

	function automatic dwl_in_t make_char(input logic [15:0] ltr, input bit last_char);
		dwl_in_t it;
		it = dwl_in_t'({$urandom, $urandom, $urandom});
		it.operation = OP_LOOKUP;
		it.letter = ltr;
		it.word_end = last_char;
		return it;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input dwl_in_t it);
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			item <= dwl_in_t'({$urandom, $urandom, $urandom});
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		follow_letter(it);
		sent_items++;
		@(negedge clk);
	endtask

	task automatic send_word(input logic [15:0] ltrs[$]);
		foreach (ltrs[i])
			send_item(make_char(ltrs[i], i == ltrs.size() - 1));
	endtask

	task automatic flag_mismatch(input string what, input dwl_out_t e, input dwl_out_t a);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected found=%b fault=%b, got found=%b fault=%b",
				$realtime, what, e.found, e.table_fault, a.found, a.table_fault);
	endtask

	always @(posedge clk) begin
		dwl_out_t e;
		if (arst_n && done) begin
			if (verdict_q.size() == 0) begin
				flag_mismatch("result with no lookup pending", '0, result);
			end else begin
				e = verdict_q.pop_front();
				if (result.found !== e.found || result.table_fault !== e.table_fault)
					flag_mismatch("wrong result", e, result);
			end
		end
	end

	// root list at 0, one child list at 2, a list that runs into the store end
	task automatic test_special_cases();
		send_item(make_write(0, 16'h0000, 1'b1, 1'b0, 16'd2));
		send_item(make_write(1, 16'hFFFF, 1'b0, 1'b1, 16'hFFFF));
		send_item(make_write(2, 16'h1234, 1'b1, 1'b1, 16'd65533));
		send_item(make_write(ADDR_LIMIT, 16'hABCD, 1'b1, 1'b0, 16'h0000));
		send_word('{16'h0000});
		send_word('{16'hFFFF});
		send_word('{16'h5555});
		send_word('{16'hFFFF, 16'h0001});
		send_word('{16'h0000, 16'h1234});
		send_word('{16'h0000, 16'h1234, 16'hABCD});
		send_word('{16'h0000, 16'h1234, 16'h1111});
		send_word('{16'h0000, 16'h1234, 16'hABCD, 16'h0000});
		send_word('{16'h7777, 16'h0000});
	endtask

	// lists packed from address 0, sometimes the last one flush with the store end
	task automatic build_graph(input int max_len);
		int          n_lists;
		int          lbase[8];
		int          lsize[8];
		int          a;
		int          r;
		int unsigned addr;
		bit          top;
		bit          l;
		logic [15:0] ltr;
		logic [15:0] off;
		n_lists = $urandom_range(2, 8);
		top = ($urandom_range(99) < 25);
		a = 0;
		for (int k = 0; k < n_lists; k++) begin
			lsize[k] = ($urandom_range(99) < 80) ? $urandom_range(1, 4) :
				$urandom_range(1, max_len);
			lbase[k] = a;
			a += lsize[k];
		end
		if (top)
			lbase[n_lists-1] = NODES - lsize[n_lists-1];
		foreach (letter_pool[i])
			letter_pool[i] = 16'($urandom_range(0, 65535));
		for (int k = 0; k < n_lists; k++) begin
			for (int j = 0; j < lsize[k]; j++) begin
				addr = lbase[k] + j;
				ltr = ($urandom_range(99) < 90) ? letter_pool[$urandom_range(0, 3)] :
					16'($urandom_range(0, 65535));
				l = (j == lsize[k] - 1);
				if (top && k == n_lists - 1 && $urandom_range(1))
					l = 1'b0;
				r = $urandom_range(99);
				if (k < n_lists - 1 && r < 70)
					off = 16'(lbase[$urandom_range(k + 1, n_lists - 1)] - addr);
				else if (r >= 90 && addr > 0)
					off = 16'($urandom_range(65535, NODES - addr));
				else
					off = '0;
				send_item(make_write(addr, ltr, 1'($urandom_range(1)), l, off));
			end
		end
	endtask

	// mostly letters of the current list, some pool letters and noise, with an occasional node write
	task automatic random_word();
		int          len;
		int          r;
		int unsigned a;
		logic [15:0] ltr;
		logic [15:0] cands[$];
		len = $urandom_range(1, 5);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 3)
				send_item(make_write($urandom_range(1000, 60000),
					16'($urandom_range(0, 65535)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 16'($urandom_range(0, 65535))));
			cands.delete();
			if (word_ok) begin
				a = cur_list;
				forever begin
					cands.push_back(node_mem[a].letter);
					if (node_mem[a].is_last || a == NODES - 1)
						break;
					a++;
				end
			end
			r = $urandom_range(99);
			if (cands.size() != 0 && r < 75)
				ltr = cands[$urandom_range(0, cands.size() - 1)];
			else if (r < 90)
				ltr = letter_pool[$urandom_range(0, 3)];
			else
				ltr = 16'($urandom_range(0, 65535));
			send_item(make_char(ltr, i == len - 1));
		end
	endtask

	task automatic run_graphs(input int budget, input int max_len);
		int stop_at;
		stop_at = sent_items + budget;
		while (sent_items < stop_at) begin
			build_graph(max_len);
			repeat ($urandom_range(10, 25))
				random_word();
		end
	endtask

	task automatic test_short_lists();
		run_graphs(700, 6);
	endtask

	task automatic test_long_lists();
		run_graphs(250, 24);
	endtask

	task automatic test_back_to_back();
		gap_pct = 0;
		run_graphs(350, 8);
		gap_pct = 10;
	endtask

	initial begin
		int waited;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_special_cases();
		test_short_lists();
		test_long_lists();
		test_back_to_back();
		start <= 1'b0;
		waited = 0;
		while (verdict_q.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (verdict_q.size() != 0) begin
			$display("%0d expected results never arrived", verdict_q.size());
			mismatches += verdict_q.size();
		end
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout");
		$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire

[files.f]
rtl/dwl_pkg.sv
rtl/dwl_node_store.sv
rtl/dwl_scan_ctrl.sv
rtl/dawg_word_lookup.sv
tb/tb_dawg_word_lookup.sv
